// ===== sv/lfu_pkg.sv =====
// Package with shared types and constants for the LFU cache table.
package lfu_pkg;

    // Request codes carried in the func field.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_WRITE  = 1'b1;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_OUT
    } t_state;

endpackage

// ===== sv/lfu_cache_table_core.sv =====
// Top level of the LFU cache table with LRU tie breaking.
//
// Channel  | Direction | tdata (low bit up)                   | tuser
// s_axis   | in        | key[31:0], value[63:32]              | func
// m_axis   | out       | read_value[31:0]                     | hit[0], evicted[1]
// cfg      | in        | capacity[4:0] by i_cfg_we/i_cfg_wdata | -
//
// A request passes from acceptance through the states scan, decide, update, output
// and idle before the next acceptance: the scan reads every address in turn for the key
// match, the occupancy count and the victim search, then a decide state follows, the
// update pass writes back counts and ranks, and the result loads in the output state.
// Reset clears the valid bits; counts and ranks are written when an entry is filled.
// A waiting result holds in the output register; the next request may start, but it
// stalls in its output cycle until the earlier result is taken.
module lfu_cache_table_core #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_value[31:0]
    output logic [1:0]  m_axis_tuser    // hit[0], evicted[1]
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW + 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // Entry storage: key/data in memories; meta in memories with valid flops.
    logic [31:0]          r_kmem [ENTRIES];
    logic [31:0]          r_dmem [ENTRIES];
    logic [COUNT_BITS-1:0] r_cmem [ENTRIES];
    logic [RW-1:0]        r_rmem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx;
    logic         r_func;
    logic [31:0]  r_key, r_val;
    logic         r_present;
    logic [IW-1:0] r_found;
    logic [CW-1:0] r_occ;
    logic         r_have_free;
    logic [IW-1:0] r_free;
    logic         r_have_vic;
    logic [IW-1:0] r_vic;
    logic [COUNT_BITS-1:0] r_vcnt;
    logic [RW-1:0] r_vrank;
    logic [RW-1:0] r_trank;
    logic [31:0]  r_tdata;
    logic [4:0]   r_cap;
    // Decided action: 0 none, touch found, insert (with or without evict).
    logic         r_do_touch, r_do_ins, r_do_evict;
    logic [IW-1:0] r_slot;

    // Registered read port.
    logic [31:0]          r_rk, r_rd;
    logic [COUNT_BITS-1:0] r_rc;
    logic [RW-1:0]        r_rr;
    logic                 r_rv, r_rphase;
    logic [IW-1:0]        r_raddr;

    logic [IW-1:0] w_addr;
    logic          w_last;
    logic [CW-1:0] w_cap;
    logic          w_out_free;

    assign w_addr = r_idx;
    assign w_last = (r_idx == IW'(ENTRIES - 1));
    assign w_cap  = ({{CW{1'b0}}, r_cap} > (CW+5)'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_cap);
    assign w_out_free = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Memory read port, one address each cycle.
    always_ff @(posedge i_clk) begin
        r_rk    <= r_kmem[w_addr];
        r_rd    <= r_dmem[w_addr];
        r_rc    <= r_cmem[w_addr];
        r_rr    <= r_rmem[w_addr];
        r_rv    <= r_valid[w_addr];
        r_raddr <= w_addr;
        r_rphase <= (r_state == ST_SCAN) || (r_state == ST_UPDATE);
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_axis_tvalid && s_axis_tready) n_state = ST_SCAN;
            ST_SCAN:   if (w_last) n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_UPDATE;
            ST_UPDATE: if (w_last) n_state = ST_OUT;
            ST_OUT:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_cap <= 5'd16;
        else if (i_cfg_we) r_cap <= i_cfg_wdata;
    end

    // Update pass consumes the previous cycle's read data.
    logic w_upd_rd;
    assign w_upd_rd  = r_rphase && (r_state == ST_UPDATE || r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_idx <= '0;
            if (s_axis_tvalid && s_axis_tready) begin
                r_func <= s_axis_tuser;
                r_key  <= s_axis_tdata[31:0];
                r_val  <= s_axis_tdata[63:32];
                r_present <= 1'b0; r_occ <= '0;
                r_have_free <= 1'b0; r_have_vic <= 1'b0;
            end
        end else if (r_state == ST_SCAN || r_state == ST_UPDATE) begin
            r_idx <= w_last ? '0 : r_idx + 1'b1;
        end
        // Scan accumulation.
        if (r_rphase && (r_state == ST_SCAN || r_state == ST_DECIDE)) begin
            if (!r_rv) begin
                if (!r_have_free) begin r_have_free <= 1'b1; r_free <= r_raddr; end
            end else begin
                r_occ <= r_occ + 1'b1;
                if (!r_present && r_rk == r_key) begin
                    r_present <= 1'b1; r_found <= r_raddr;
                    r_trank <= r_rr; r_tdata <= r_rd;
                end
                if (!r_have_vic || r_rc < r_vcnt || (r_rc == r_vcnt && r_rr > r_vrank)) begin
                    r_have_vic <= 1'b1; r_vic <= r_raddr; r_vcnt <= r_rc; r_vrank <= r_rr;
                end
            end
        end
        // Decide action once all entries are seen (occupancy includes last).
        if (r_state == ST_UPDATE && r_idx == '0) begin
            r_do_touch <= r_present && (r_func == FUNC_LOOKUP || w_cap != '0);
            r_do_ins   <= !r_present && r_func == FUNC_WRITE && w_cap != '0 &&
                          (r_occ >= w_cap ? r_have_vic : r_have_free);
            r_do_evict <= !r_present && r_func == FUNC_WRITE && w_cap != '0 &&
                          r_occ >= w_cap && r_have_vic;
            r_slot     <= (r_occ >= w_cap) ? r_vic : r_free;
        end
    end

    // Read-modify-write of ranks and counts in the update pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_upd_rd) begin
            if (r_do_touch) begin
                if (r_raddr == r_found) begin
                    r_cmem[r_raddr] <= (r_rc < CMAX) ? r_rc + 1'b1 : r_rc;
                    r_rmem[r_raddr] <= '0;
                    if (r_func == FUNC_WRITE) r_dmem[r_raddr] <= r_val;
                end else if (r_rv && r_rr < r_trank) begin
                    r_rmem[r_raddr] <= r_rr + 1'b1;
                end
            end else if (r_do_ins) begin
                if (r_raddr == r_slot) begin
                    r_valid[r_raddr] <= 1'b1;
                    r_kmem[r_raddr] <= r_key;
                    r_dmem[r_raddr] <= r_val;
                    r_cmem[r_raddr] <= COUNT_BITS'(1);
                    r_rmem[r_raddr] <= '0;
                end else if (r_rv) begin
                    r_rmem[r_raddr] <= (r_do_evict && r_rr > r_vrank) ? r_rr : r_rr + 1'b1;
                end
            end
        end
    end

    // Output register; a new result loads only once the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= (r_func == FUNC_WRITE) ? 32'd0 :
                             (r_present ? r_tdata : 32'hFFFF_FFFF);
            m_axis_tuser  <= {r_do_evict, r_present};
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    // Checks on the sequencer and results.
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_evict_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
        else $error("evict on hit");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> m_axis_tvalid) else $error("result lost");
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the LFU cache table core.
`timescale 1ns / 1ps

module tb;
    import lfu_pkg::*;

    localparam int NSLOT     = 16;
    localparam int CNT_MAX   = 65535;
    localparam int N_RANDOM  = 1330;
    localparam int IDLE_WAIT = 200;
    localparam int WDOG_MAX  = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    typedef struct packed {
        logic        hit;
        logic [31:0] rdata;
        logic        evicted;
    } t_resp;

    typedef struct {
        logic        func;
        logic [31:0] key;
        logic [31:0] value;
        logic        chk;
        t_resp       resp;
    } t_row;

    // Shadow copy of the table.
    int unsigned cap_reg;
    logic        sh_valid [NSLOT];
    logic [31:0] sh_key   [NSLOT];
    logic [31:0] sh_data  [NSLOT];
    int unsigned sh_uses  [NSLOT];
    int unsigned sh_rank  [NSLOT];

    t_resp       resp_q[$];
    t_resp       fixed_q[$];
    logic        fixed_flag_q[$];
    int          n_err;
    int          stall_mode;
    logic        hold_sink;
    int          quiet_cycles;

    lfu_cache_table_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report_err(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        n_err++;
    endtask

    function automatic void shadow_reset();
        cap_reg = 16;
        for (int i = 0; i < NSLOT; i++) begin
            sh_valid[i] = 1'b0;
            sh_uses[i]  = 0;
            sh_rank[i]  = 0;
        end
    endfunction

    // Move an entry to the front of the recency order and count the use.
    function automatic void bump_use(input int e);
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_valid[i] && i != e && sh_rank[i] < sh_rank[e]) sh_rank[i]++;
        end
        sh_rank[e] = 0;
        if (sh_uses[e] < CNT_MAX) sh_uses[e]++;
    endfunction

    // Apply one request to the shadow table and return its response.
    function automatic t_resp cache_access(input logic func, input logic [31:0] key,
                                           input logic [31:0] value);
        t_resp       r;
        int          found;
        int          occ;
        int          slot;
        int unsigned cap;
        logic        have;
        found = -1;
        occ = 0;
        slot = 0;
        have = 1'b0;
        cap = (cap_reg > NSLOT) ? NSLOT : cap_reg;
        r = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_valid[i]) begin
                occ++;
                if (found < 0 && sh_key[i] == key) found = i;
            end
        end
        r.hit = (found >= 0);
        if (func == FUNC_LOOKUP) begin
            r.rdata = '1;
            if (found >= 0) begin
                bump_use(found);
                r.rdata = sh_data[found];
            end
        end else if (cap != 0) begin
            if (found >= 0) begin
                sh_data[found] = value;
                bump_use(found);
            end else begin
                if (occ >= cap) begin
                    // Victim: fewest uses, then the oldest access.
                    for (int i = 0; i < NSLOT; i++) begin
                        if (sh_valid[i] && (!have || sh_uses[i] < sh_uses[slot] ||
                            (sh_uses[i] == sh_uses[slot] && sh_rank[i] > sh_rank[slot])))
                        begin
                            slot = i;
                            have = 1'b1;
                        end
                    end
                    if (have) begin
                        sh_valid[slot] = 1'b0;
                        for (int i = 0; i < NSLOT; i++) begin
                            if (sh_valid[i] && sh_rank[i] > sh_rank[slot]) sh_rank[i]--;
                        end
                        r.evicted = 1'b1;
                    end
                end else begin
                    for (int i = NSLOT - 1; i >= 0; i--) begin
                        if (!sh_valid[i]) begin
                            slot = i;
                            have = 1'b1;
                        end
                    end
                end
                if (have) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (sh_valid[i]) sh_rank[i]++;
                    end
                    sh_valid[slot] = 1'b1;
                    sh_key[slot]   = key;
                    sh_data[slot]  = value;
                    sh_uses[slot]  = 1;
                    sh_rank[slot]  = 0;
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (stall_mode == 0) return 0;
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and wait until it is taken; with no gap the next item is offered
    // right after, with valid held high.
    task automatic send_item(input logic func, input logic [31:0] key,
                             input logic [31:0] value, input logic chk, input t_resp want);
        t_resp r;
        int    g;
        r = cache_access(func, key, value);
        resp_q.push_back(r);
        fixed_q.push_back(want);
        fixed_flag_q.push_back(chk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        drain_wait();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_reg = {27'd0, v};
    endtask

    // Random key from a small pool so that hits and evictions are common.
    function automatic logic [31:0] pick_key(input int pool);
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return $urandom;
        if (p == 1) return 32'h8000_0000 + $urandom_range(0, 3);
        return $urandom_range(0, pool - 1);
    endfunction

    // Sink side: random stall, with a long forced hold when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_sink) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (gap_len() == 0);
        end
    end

    // Check each result against the oldest expectation.
    always @(posedge i_clk) begin
        t_resp e;
        t_resp f;
        logic  fc;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (resp_q.size() == 0) begin
                report_err("unexpected result", m_axis_tdata, 32'h0);
            end else begin
                e  = resp_q.pop_front();
                f  = fixed_q.pop_front();
                fc = fixed_flag_q.pop_front();
                if (fc && f != e) begin
                    report_err("table row vs predictor", e.rdata, f.rdata);
                end
                if (m_axis_tuser[0] != e.hit) begin
                    report_err("hit", 32'(m_axis_tuser[0]), 32'(e.hit));
                end
                if (m_axis_tdata != e.rdata) report_err("read_value", m_axis_tdata, e.rdata);
                if (m_axis_tuser[1] != e.evicted) begin
                    report_err("evicted", 32'(m_axis_tuser[1]), 32'(e.evicted));
                end
            end
        end
    end

    // Watchdog on cycles with no item accepted at the input or taken at the output.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Long hold of the sink, counted in its own process.
    initial begin
        hold_sink = 1'b0;
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    initial begin
        t_row  rows[$];
        t_row  row;
        t_resp rsp;
        int    pool;
        logic  func;

        n_err         = 0;
        stall_mode    = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_LOOKUP;
        shadow_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: func, key, value, fixed check, expected response.
        rows = '{
            '{FUNC_LOOKUP, 32'h0000_0000, 32'h0, 1'b1, '{1'b0, 32'hFFFF_FFFF, 1'b0}},
            '{FUNC_WRITE,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
            '{FUNC_WRITE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
            '{FUNC_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
            '{FUNC_LOOKUP, 32'h8000_0000, 32'h1234_5678, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0}},
            '{FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
            '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
            '{FUNC_WRITE,  32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 1'b0}},
            '{FUNC_LOOKUP, 32'h8000_0000, 32'h0, 1'b1, '{1'b1, 32'h0, 1'b0}},
            '{FUNC_LOOKUP, 32'h0000_0001, 32'h0, 1'b1, '{1'b0, 32'hFFFF_FFFF, 1'b0}}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.func, row.key, row.value, row.chk, row.resp);
        end

        // Capacity two: eviction by fewest uses, then by oldest access.
        write_capacity(5'd2);
        for (int k = 10; k < 16; k++) send_item(FUNC_WRITE, k, ~k, 1'b0, '0);
        send_item(FUNC_LOOKUP, 14, 0, 1'b0, '0);
        send_item(FUNC_WRITE, 20, 20, 1'b0, '0);
        send_item(FUNC_LOOKUP, 15, 0, 1'b0, '0);

        // Capacity zero: writes are ignored, lookups still see stored entries.
        write_capacity(5'd0);
        send_item(FUNC_WRITE, 14, 99, 1'b0, '0);
        send_item(FUNC_WRITE, 77, 77, 1'b1, '{1'b0, 32'h0, 1'b0});
        send_item(FUNC_LOOKUP, 77, 0, 1'b1, '{1'b0, 32'hFFFF_FFFF, 1'b0});
        send_item(FUNC_LOOKUP, 14, 0, 1'b0, '0);

        // Random phases over several capacities, extremes included.
        stall_mode = 1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_capacity(5'd31);
                1: write_capacity(5'd16);
                2: write_capacity(5'd1);
                3: write_capacity(5'($urandom_range(3, 15)));
                4: write_capacity(5'd0);
                default: write_capacity(5'd17);
            endcase
            pool = (ph == 2) ? 4 : $urandom_range(8, 40);
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                func = 1'($urandom_range(0, 1));
                send_item(func, pick_key(pool), $urandom, 1'b0, '0);
                if (n == 100) stall_mode = 0;
                if (n == 150) stall_mode = 1;
            end
        end

        // Hammer one key to push its use count toward the top.
        write_capacity(5'd16);
        stall_mode = 0;
        for (int n = 0; n < 50; n++) send_item(FUNC_LOOKUP, 5, 0, 1'b0, '0);

        drain_wait();
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
